>>> sv/ift_pkg.sv
// Shared types, widths and constants of the ion flight time pipeline.
`default_nettype none

package ift_pkg;

    // Fixed-point formats of position, time and the internal velocities.
    localparam int POS_FRAC_BITS  = 16;
    localparam int TIME_FRAC_BITS = 8;
    localparam int VEL_FRAC_BITS  = 40;

    // Port field widths.
    localparam int POS_W  = 20;
    localparam int MASS_W = 8;
    localparam int CFG_W  = 16;
    localparam int TIME_W = 32;

    // Full-scale position (x = 5) and the derived datapath widths.
    localparam int D_W  = POS_FRAC_BITS + 3;
    localparam logic [D_W-1:0] POS_FULL = D_W'(5) << POS_FRAC_BITS;
    localparam int E_W  = D_W + CFG_W;
    localparam int MD_W = D_W + MASS_W;

    // Velocity: quotient of energy << (2*VEL_FRAC_BITS) over mass * full scale.
    localparam int QV_W  = E_W + 2 * VEL_FRAC_BITS - POS_FRAC_BITS - 2;
    localparam int QV_SH = QV_W - 2 * VEL_FRAC_BITS;
    localparam int SQ_W  = (QV_W + 1) / 2;
    localparam int NP_W  = 2 * SQ_W;
    localparam int R_W   = SQ_W + 1;

    // Velocity scale factor in Q.48.
    localparam int K_W    = 42;
    localparam int K_FRAC = 48;
    localparam logic [K_W-1:0] K_Q48 = 42'd4122826548810;
    localparam int K_LO_W = (K_W + 1) / 2;
    localparam int K_HI_W = K_W - K_LO_W;
    localparam int S_LO_W = (SQ_W + 1) / 2;
    localparam int S_HI_W = SQ_W - S_LO_W;
    localparam int P_W    = SQ_W + K_W;
    localparam int V_W    = P_W - K_FRAC;
    localparam int VS_W   = V_W + 1;

    // Time term numerators and denominators.
    localparam int TSH    = VEL_FRAC_BITS + TIME_FRAC_BITS - POS_FRAC_BITS;
    localparam int N0_W   = POS_FRAC_BITS + 8;
    localparam logic [N0_W-1:0] GAP_LEN = N0_W'(170) << POS_FRAC_BITS;
    localparam int N1_W   = E_W + 2;
    localparam int N2_W   = E_W + 4;
    localparam int DEN0_W = V_W;
    localparam int DEN1_W = CFG_W + VS_W;
    localparam int DEN2_W = CFG_W + V_W;

    // Each time term is clamped at 2^40.
    localparam int TQ_W = 41;
    localparam logic [TQ_W-1:0] TERM_CAP = TQ_W'(1) << (TQ_W - 1);
    localparam int SUM_W = TQ_W + 2;

    // Pipeline depths.
    localparam int LV = QV_W + SQ_W + 3;
    localparam int LT = TQ_W + 2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE  = 2'd0,
        CFG_MIN     = 2'd1,
        CFG_MIRROR1 = 2'd2,
        CFG_MIRROR2 = 2'd3
    } t_cfg_idx;

    // Input item.
    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic [MASS_W-1:0]       mass;
    } t_in;

    // Result item.
    typedef struct packed {
        logic [TIME_W-1:0] flight_time;
        logic              rejected;
        logic              saturated;
    } t_out;

    // Item data that travels beside the velocity units.
    typedef struct packed {
        logic            rej;
        logic            two;
        logic [N0_W-1:0] n0;
        logic [E_W-1:0]  e;
        logic [E_W-1:0]  g;
    } t_side;

endpackage

`default_nettype wire

>>> sv/ift_div_cell.sv
// One restoring division step: one quotient bit per cell and cycle while i_en is high.
`default_nettype none

module ift_div_cell #(
    parameter int N_W   = 8,
    parameter int SHIFT = 0,
    parameter int BIT   = 0,
    parameter int DEN_W = 8,
    parameter int Q_W   = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [N_W-1:0]   i_n,
    input  wire logic [DEN_W-1:0] i_den,
    input  wire logic [DEN_W-1:0] i_rem,
    input  wire logic [Q_W-1:0]   i_quo,
    output logic      [N_W-1:0]   o_n,
    output logic      [DEN_W-1:0] o_den,
    output logic      [DEN_W-1:0] o_rem,
    output logic      [Q_W-1:0]   o_quo
);

    logic             w_nbit;
    logic [DEN_W:0]   w_cat;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    // The numerator is i_n shifted left by SHIFT; pick this cell's bit of it.
    generate
        if (BIT >= SHIFT) begin : g_bit
            assign w_nbit = i_n[BIT-SHIFT];
        end else begin : g_zero
            assign w_nbit = 1'b0;
        end
    endgenerate

    // Bring down the next bit and subtract the divisor when it fits.
    assign w_cat  = {i_rem, w_nbit};
    assign w_ge   = (w_cat >= {1'b0, i_den});
    assign w_diff = w_cat - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_n   <= i_n;
            o_den <= i_den;
            o_rem <= w_ge ? w_diff[DEN_W-1:0] : w_cat[DEN_W-1:0];
            o_quo <= {i_quo[Q_W-2:0], w_ge};
        end
    end

endmodule

`default_nettype wire

>>> sv/ift_sqrt_cell.sv
// One digit step of an integer square root: one result bit per cell and cycle while i_en is high.
`default_nettype none

module ift_sqrt_cell #(
    parameter int STEP = 0
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic [ift_pkg::NP_W-1:0]  i_n,
    input  wire logic [ift_pkg::R_W-1:0]   i_rem,
    input  wire logic [ift_pkg::SQ_W-1:0]  i_root,
    output logic      [ift_pkg::NP_W-1:0]  o_n,
    output logic      [ift_pkg::R_W-1:0]   o_rem,
    output logic      [ift_pkg::SQ_W-1:0]  o_root
);

    logic [ift_pkg::R_W+1:0] w_cat;
    logic [ift_pkg::R_W+1:0] w_trial;
    logic [ift_pkg::R_W+1:0] w_diff;
    logic                    w_ge;

    // Append the next bit pair and try the root bit set to one.
    assign w_cat   = {i_rem, i_n[2*STEP+1], i_n[2*STEP]};
    assign w_trial = {1'b0, i_root, 2'b01};
    assign w_ge    = (w_cat >= w_trial);
    assign w_diff  = w_cat - w_trial;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_n    <= i_n;
            o_rem  <= w_ge ? w_diff[ift_pkg::R_W-1:0] : w_cat[ift_pkg::R_W-1:0];
            o_root <= {i_root[ift_pkg::SQ_W-2:0], w_ge};
        end
    end

endmodule

`default_nettype wire

>>> sv/ift_velocity.sv
// Velocity unit: divider chain, square root chain and scale multiplier.
`default_nettype none

module ift_velocity (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic [ift_pkg::E_W-1:0]  i_energy,
    input  wire logic [ift_pkg::MD_W-1:0] i_md,
    output logic      [ift_pkg::V_W-1:0]  o_vel
);

    localparam int QV_W   = ift_pkg::QV_W;
    localparam int SQ_W   = ift_pkg::SQ_W;
    localparam int P_W    = ift_pkg::P_W;
    localparam int S_LO_W = ift_pkg::S_LO_W;
    localparam int S_HI_W = ift_pkg::S_HI_W;
    localparam int K_LO_W = ift_pkg::K_LO_W;
    localparam int K_HI_W = ift_pkg::K_HI_W;
    localparam logic [K_LO_W-1:0] K_LO = ift_pkg::K_Q48[K_LO_W-1:0];
    localparam logic [K_HI_W-1:0] K_HI = ift_pkg::K_Q48[ift_pkg::K_W-1:K_LO_W];

    logic [ift_pkg::E_W-1:0]  dv_n   [0:QV_W];
    logic [ift_pkg::MD_W-1:0] dv_den [0:QV_W];
    logic [ift_pkg::MD_W-1:0] dv_rem [0:QV_W];
    logic [QV_W-1:0]          dv_quo [0:QV_W];

    logic [ift_pkg::NP_W-1:0] sq_n    [0:SQ_W];
    logic [ift_pkg::R_W-1:0]  sq_rem  [0:SQ_W];
    logic [SQ_W-1:0]          sq_root [0:SQ_W];

    logic [S_LO_W+K_LO_W-1:0] r_pll;
    logic [S_LO_W+K_HI_W-1:0] r_plh;
    logic [S_HI_W+K_LO_W-1:0] r_phl;
    logic [S_HI_W+K_HI_W-1:0] r_phh;
    logic [P_W-1:0]           r_a;
    logic [P_W-1:0]           r_b;
    logic [P_W-1:0]           w_p;
    logic [SQ_W-1:0]          w_s;

    // The top of the shifted numerator is below the divisor, so it seeds the remainder.
    assign dv_n[0]   = i_energy;
    assign dv_den[0] = i_md;
    assign dv_rem[0] = ift_pkg::MD_W'(i_energy >> ift_pkg::QV_SH);
    assign dv_quo[0] = '0;

    // Divider chain, most significant quotient bit first.
    genvar j;
    generate
        for (j = 0; j < QV_W; j++) begin : g_div
            ift_div_cell #(
                .N_W   (ift_pkg::E_W),
                .SHIFT (2 * ift_pkg::VEL_FRAC_BITS),
                .BIT   (QV_W - 1 - j),
                .DEN_W (ift_pkg::MD_W),
                .Q_W   (QV_W)
            ) u_cell (
                .i_clk (i_clk),
                .i_en  (i_en),
                .i_n   (dv_n[j]),
                .i_den (dv_den[j]),
                .i_rem (dv_rem[j]),
                .i_quo (dv_quo[j]),
                .o_n   (dv_n[j+1]),
                .o_den (dv_den[j+1]),
                .o_rem (dv_rem[j+1]),
                .o_quo (dv_quo[j+1])
            );
        end
    endgenerate

    // Square root chain over the quotient, two bits per cell.
    assign sq_n[0]    = ift_pkg::NP_W'(dv_quo[QV_W]);
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    genvar k;
    generate
        for (k = 0; k < SQ_W; k++) begin : g_sqrt
            ift_sqrt_cell #(
                .STEP (SQ_W - 1 - k)
            ) u_cell (
                .i_clk  (i_clk),
                .i_en   (i_en),
                .i_n    (sq_n[k]),
                .i_rem  (sq_rem[k]),
                .i_root (sq_root[k]),
                .o_n    (sq_n[k+1]),
                .o_rem  (sq_rem[k+1]),
                .o_root (sq_root[k+1])
            );
        end
    endgenerate

    assign w_s = sq_root[SQ_W];

    // Scale by k in three stages: partial products, pair sums, final sum.
    assign w_p = r_a + (r_b << S_LO_W);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pll <= w_s[S_LO_W-1:0] * K_LO;
            r_plh <= w_s[S_LO_W-1:0] * K_HI;
            r_phl <= w_s[SQ_W-1:S_LO_W] * K_LO;
            r_phh <= w_s[SQ_W-1:S_LO_W] * K_HI;
            r_a   <= P_W'(r_pll) + (P_W'(r_plh) << K_LO_W);
            r_b   <= P_W'(r_phl) + (P_W'(r_phh) << K_LO_W);
            o_vel <= w_p[P_W-1:ift_pkg::K_FRAC];
        end
    end

endmodule

`default_nettype wire

>>> sv/ift_tdiv.sv
// Time term divider: overflow check, bit-per-cell quotient chain and clamp.
`default_nettype none

module ift_tdiv #(
    parameter int N_W   = 24,
    parameter int DEN_W = 43
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic [N_W-1:0]           i_num,
    input  wire logic [DEN_W-1:0]         i_den,
    output logic      [ift_pkg::TQ_W-1:0] o_term
);

    localparam int TQ_W = ift_pkg::TQ_W;
    localparam int NF_W = N_W + ift_pkg::TSH;
    localparam int HI_W = NF_W - TQ_W;
    localparam int C_W  = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic [NF_W-1:0]  w_full;
    logic [HI_W-1:0]  w_hi;
    logic             w_ovf;

    logic [N_W-1:0]   r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem0;
    logic [TQ_W:0]    r_ovf;

    logic [N_W-1:0]   c_n   [0:TQ_W];
    logic [DEN_W-1:0] c_den [0:TQ_W];
    logic [DEN_W-1:0] c_rem [0:TQ_W];
    logic [TQ_W-1:0]  c_quo [0:TQ_W];

    // A quotient of 2^TQ_W or more, or a zero divisor, clamps the term.
    assign w_full = NF_W'(i_num) << ift_pkg::TSH;
    assign w_hi   = w_full[NF_W-1:TQ_W];
    assign w_ovf  = (C_W'(w_hi) >= C_W'(i_den));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem0 <= DEN_W'(w_hi);
            r_ovf  <= {r_ovf[TQ_W-1:0], w_ovf};
        end
    end

    assign c_n[0]   = r_num;
    assign c_den[0] = r_den;
    assign c_rem[0] = r_rem0;
    assign c_quo[0] = '0;

    // Quotient chain, most significant bit first.
    genvar j;
    generate
        for (j = 0; j < TQ_W; j++) begin : g_div
            ift_div_cell #(
                .N_W   (N_W),
                .SHIFT (ift_pkg::TSH),
                .BIT   (TQ_W - 1 - j),
                .DEN_W (DEN_W),
                .Q_W   (TQ_W)
            ) u_cell (
                .i_clk (i_clk),
                .i_en  (i_en),
                .i_n   (c_n[j]),
                .i_den (c_den[j]),
                .i_rem (c_rem[j]),
                .i_quo (c_quo[j]),
                .o_n   (c_n[j+1]),
                .o_den (c_den[j+1]),
                .o_rem (c_rem[j+1]),
                .o_quo (c_quo[j+1])
            );
        end
    endgenerate

    // Clamp the finished term at the cap.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_ovf[TQ_W] || (c_quo[TQ_W] > ift_pkg::TERM_CAP)) begin
                o_term <= ift_pkg::TERM_CAP;
            end else begin
                o_term <= c_quo[TQ_W];
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/ion_flight_time_top.sv
// Ion flight time pipeline: energy check, velocities, time terms and result buffer.
//
// Usage: an ion (position, mass) is taken on the input channel when i_in_valid is
// high and o_in_stall is low. Each ion yields exactly one result on the output
// channel, taken when o_out_valid is high and i_out_stall is low. Results leave
// in input order.
// An ion passes three front stages, two velocity units of 149 stages (a 97-cell
// divider chain, a 49-cell square root chain and a 3-stage multiplier), two stages
// for the mirror denominators, three parallel 43-stage time dividers, the sum and
// the output register. One ion is taken every cycle while o_in_stall is low.
// A two-entry output buffer keeps taking results while the receiver stalls; once
// both entries hold results, o_in_stall rises and the whole pipeline holds until
// the receiver takes one.
// Configuration registers are written through the cfg channel (always ready) and
// must only change while no ion is in flight.
// Reset empties the pipeline and the output buffer and loads source 600 V,
// minimum 0 V and both mirrors 600 V.
`default_nettype none

module ion_flight_time_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire ift_pkg::t_in                  i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output ift_pkg::t_out                      o_out_data,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [ift_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ift_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int LV   = ift_pkg::LV;
    localparam int LT   = ift_pkg::LT;
    localparam int E_W  = ift_pkg::E_W;
    localparam int D_W  = ift_pkg::D_W;
    localparam int TQ_W = ift_pkg::TQ_W;
    localparam int SUM_W = ift_pkg::SUM_W;

    // Configuration registers.
    logic [ift_pkg::CFG_W-1:0] r_src_v;
    logic [ift_pkg::CFG_W-1:0] r_min_v;
    logic [ift_pkg::CFG_W-1:0] r_m1_v;
    logic [ift_pkg::CFG_W-1:0] r_m2_v;

    logic w_en;

    // Front stages.
    logic                          r1_valid;
    logic [ift_pkg::POS_W-1:0]     r1_pos;
    logic [ift_pkg::MASS_W-1:0]    r1_mass;
    logic                          r2_valid;
    logic                          r2_prej;
    logic [D_W-1:0]                r2_pos;
    logic [E_W-1:0]                r2_e;
    logic [ift_pkg::MASS_W-1:0]    r2_mass;
    logic                          r3_valid;
    ift_pkg::t_side                r3_side;
    logic [ift_pkg::MD_W-1:0]      r3_md;

    logic [E_W-1:0]                w_mind;
    logic [E_W-1:0]                w_m1d;
    logic [E_W-1:0]                w_m2d;
    logic                          w_two;
    ift_pkg::t_side                w_side;

    // Line beside the velocity units.
    logic [LV-1:0]                 r_dv_valid;
    ift_pkg::t_side                r_dv [0:LV-1];
    logic [ift_pkg::V_W-1:0]       w_vis;
    logic [ift_pkg::V_W-1:0]       w_vm;

    // Denominator stages.
    logic                          r4_valid;
    logic                          r4_rej;
    logic                          r4_two;
    logic [ift_pkg::N0_W-1:0]      r4_n0;
    logic [ift_pkg::N1_W-1:0]      r4_n1;
    logic [ift_pkg::N2_W-1:0]      r4_n2;
    logic [ift_pkg::V_W-1:0]       r4_vis;
    logic [ift_pkg::V_W-1:0]       r4_vm;
    logic [ift_pkg::VS_W-1:0]      r4_vsum;
    logic                          r5_valid;
    logic                          r5_rej;
    logic                          r5_two;
    logic [ift_pkg::N0_W-1:0]      r5_n0;
    logic [ift_pkg::N1_W-1:0]      r5_n1;
    logic [ift_pkg::N2_W-1:0]      r5_n2;
    logic [ift_pkg::DEN0_W-1:0]    r5_den0;
    logic [ift_pkg::DEN1_W-1:0]    r5_den1;
    logic [ift_pkg::DEN2_W-1:0]    r5_den2;

    // Line beside the time dividers.
    logic [LT-1:0]                 r_dt_valid;
    logic [LT-1:0]                 r_dt_rej;
    logic [LT-1:0]                 r_dt_two;
    logic [TQ_W-1:0]               w_t0;
    logic [TQ_W-1:0]               w_t1;
    logic [TQ_W-1:0]               w_t2;

    // Sum stage and output buffer.
    logic                          r6_valid;
    logic                          r6_rej;
    logic [SUM_W-1:0]              r6_sum;
    ift_pkg::t_out                 w_res;
    logic                          w_arrive;
    logic                          w_take;
    logic                          r_out_valid;
    ift_pkg::t_out                 r_out;
    logic                          r_skid_valid;
    ift_pkg::t_out                 r_skid;

    // Configuration writes; the port never pushes back.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_v <= ift_pkg::CFG_W'(600);
            r_min_v <= '0;
            r_m1_v  <= ift_pkg::CFG_W'(600);
            r_m2_v  <= ift_pkg::CFG_W'(600);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ift_pkg::CFG_SOURCE:  r_src_v <= i_cfg_data;
                ift_pkg::CFG_MIN:     r_min_v <= i_cfg_data;
                ift_pkg::CFG_MIRROR1: r_m1_v  <= i_cfg_data;
                ift_pkg::CFG_MIRROR2: r_m2_v  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The pipeline advances whenever the second buffer entry is free.
    assign w_en       = !r_skid_valid;
    assign o_in_stall = r_skid_valid;

    // Valid bits of the whole chain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid   <= 1'b0;
            r2_valid   <= 1'b0;
            r3_valid   <= 1'b0;
            r_dv_valid <= '0;
            r4_valid   <= 1'b0;
            r5_valid   <= 1'b0;
            r_dt_valid <= '0;
            r6_valid   <= 1'b0;
        end else if (w_en) begin
            r1_valid   <= i_in_valid;
            r2_valid   <= r1_valid;
            r3_valid   <= r2_valid;
            r_dv_valid <= {r_dv_valid[LV-2:0], r3_valid};
            r4_valid   <= r_dv_valid[LV-1];
            r5_valid   <= r4_valid;
            r_dt_valid <= {r_dt_valid[LT-2:0], r5_valid};
            r6_valid   <= r_dt_valid[LT-1];
        end
    end

    // Stage 1 registers the ion, stage 2 checks the position and forms the energy.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_pos  <= i_in_data.position;
            r1_mass <= i_in_data.mass;
            r2_prej <= r1_pos[ift_pkg::POS_W-1] || (r1_pos == '0) ||
                       (r1_pos > ift_pkg::POS_W'(ift_pkg::POS_FULL));
            r2_pos  <= r1_pos[D_W-1:0];
            r2_e    <= E_W'(r1_pos[D_W-1:0]) * E_W'(r_src_v);
            r2_mass <= (r1_mass == '0) ? ift_pkg::MASS_W'(1) : r1_mass;
        end
    end

    // Stage 3 compares the energy with the voltage window and picks the mirror case.
    assign w_mind = E_W'(r_min_v) * E_W'(ift_pkg::POS_FULL);
    assign w_m1d  = E_W'(r_m1_v) * E_W'(ift_pkg::POS_FULL);
    assign w_m2d  = E_W'(r_m2_v) * E_W'(ift_pkg::POS_FULL);
    assign w_two  = (r2_e > w_m1d);

    always_comb begin
        w_side.rej = r2_prej || (r2_e < w_mind) || (w_two && (r2_e > w_m2d));
        w_side.two = w_two;
        w_side.n0  = ift_pkg::N0_W'({r2_pos, 1'b0}) + ift_pkg::GAP_LEN;
        w_side.e   = r2_e;
        w_side.g   = w_two ? (r2_e - w_m1d) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_side <= w_side;
            r3_md   <= ift_pkg::MD_W'(r2_mass) * ift_pkg::MD_W'(ift_pkg::POS_FULL);
        end
    end

    // Velocities in the source and behind the first mirror stage.
    ift_velocity u_vis (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_energy (r3_side.e),
        .i_md     (r3_md),
        .o_vel    (w_vis)
    );

    ift_velocity u_vm (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_energy (r3_side.g),
        .i_md     (r3_md),
        .o_vel    (w_vm)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv[0] <= r3_side;
            for (int k = 1; k < LV; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
        end
    end

    // Stage 4 forms numerators and the velocity sum, stage 5 the denominators.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_rej  <= r_dv[LV-1].rej;
            r4_two  <= r_dv[LV-1].two;
            r4_n0   <= r_dv[LV-1].n0;
            r4_n1   <= ift_pkg::N1_W'(r_dv[LV-1].e) << 2;
            r4_n2   <= ift_pkg::N2_W'(r_dv[LV-1].g) * ift_pkg::N2_W'(12);
            r4_vis  <= w_vis;
            r4_vm   <= w_vm;
            r4_vsum <= r_dv[LV-1].two ? (ift_pkg::VS_W'(w_vis) + ift_pkg::VS_W'(w_vm))
                                      : ift_pkg::VS_W'(w_vis);
            r5_rej  <= r4_rej;
            r5_two  <= r4_two;
            r5_n0   <= r4_n0;
            r5_n1   <= r4_n1;
            r5_n2   <= r4_n2;
            r5_den0 <= r4_vis;
            r5_den1 <= ift_pkg::DEN1_W'(r_m1_v) * ift_pkg::DEN1_W'(r4_vsum);
            r5_den2 <= ift_pkg::DEN2_W'(r_m2_v) * ift_pkg::DEN2_W'(r4_vm);
        end
    end

    // Source and gap time, first mirror time, second mirror time.
    ift_tdiv #(
        .N_W   (ift_pkg::N0_W),
        .DEN_W (ift_pkg::DEN0_W)
    ) u_t0 (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r5_n0),
        .i_den  (r5_den0),
        .o_term (w_t0)
    );

    ift_tdiv #(
        .N_W   (ift_pkg::N1_W),
        .DEN_W (ift_pkg::DEN1_W)
    ) u_t1 (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r5_n1),
        .i_den  (r5_den1),
        .o_term (w_t1)
    );

    ift_tdiv #(
        .N_W   (ift_pkg::N2_W),
        .DEN_W (ift_pkg::DEN2_W)
    ) u_t2 (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r5_n2),
        .i_den  (r5_den2),
        .o_term (w_t2)
    );

    // Flags beside the dividers, then the sum of the terms.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dt_rej <= {r_dt_rej[LT-2:0], r5_rej};
            r_dt_two <= {r_dt_two[LT-2:0], r5_two};
            r6_rej   <= r_dt_rej[LT-1];
            r6_sum   <= SUM_W'(w_t0) + SUM_W'(w_t1) +
                        (r_dt_two[LT-1] ? SUM_W'(w_t2) : '0);
        end
    end

    // Result: zero when rejected, all ones when the time does not fit.
    always_comb begin
        if (r6_rej) begin
            w_res.flight_time = '0;
            w_res.rejected    = 1'b1;
            w_res.saturated   = 1'b0;
        end else if (r6_sum[SUM_W-1:ift_pkg::TIME_W] != '0) begin
            w_res.flight_time = '1;
            w_res.rejected    = 1'b0;
            w_res.saturated   = 1'b1;
        end else begin
            w_res.flight_time = r6_sum[ift_pkg::TIME_W-1:0];
            w_res.rejected    = 1'b0;
            w_res.saturated   = 1'b0;
        end
    end

    // Output register plus one skid entry.
    assign w_arrive = w_en && r6_valid;
    assign w_take   = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_arrive) begin
            if (!r_out_valid || w_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (w_arrive) begin
            if (!r_out_valid || w_take) begin
                r_out <= w_res;
            end else begin
                r_skid <= w_res;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The skid entry is only filled behind a waiting output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a result while the output register is empty");

    // A full skid entry only drains through a transfer on the output.
    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !w_take) |=> r_skid_valid)
        else $error("skid entry dropped without an output transfer");

    // A rejected ion carries time zero and no saturation.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.rejected) |->
        (o_out_data.flight_time == '0 && !o_out_data.saturated))
        else $error("rejected result with nonzero time or saturation");

    // A saturated time is the full-scale value.
    a_sat_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.saturated) |-> (o_out_data.flight_time == '1))
        else $error("saturated result below full scale");

endmodule

`default_nettype wire
